// File: rtl/core/pps_pkg.sv
// Shared constants, codes and types for the preemptive priority scheduler.
package pps_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int TIME_W    = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int PID_W     = 8;
  localparam int BURST_W   = 12;
  localparam int PRIO_W    = 8;
  localparam int REQ_W     = 2;
  localparam int CFG_W     = 5;
  localparam int OSLOT_W   = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // one slot record as held in the slot RAM
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  completion;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic capture;
    logic do_load;
    logic tick_start;
    logic scan_step;
    logic time_inc;
    logic rd_best;
    logic rd_slot;
    logic cap_read;
    logic cap_tick;
    logic calc_tat;
    logic calc_wt;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] in_req;
    logic             scan_done;
    logic             found;
    logic             out_busy;
  } dp_stat_t;

endpackage

// File: rtl/core/pps_req_if.sv
// Request channel: valid/ready handshake with one scheduler request.
interface pps_req_if;
  logic                       valid;
  logic                       ready;
  logic [pps_pkg::REQ_W-1:0]  req_type;
  logic [pps_pkg::SLOT_W-1:0] slot_index;
  logic [pps_pkg::PID_W-1:0]  proc_id;
  logic [pps_pkg::TIME_W-1:0] arrival_time;
  logic [pps_pkg::BURST_W-1:0] burst_length;
  logic [pps_pkg::PRIO_W-1:0] prio_level;

  modport source (output valid, req_type, slot_index, proc_id, arrival_time,
                  burst_length, prio_level, input ready);
  modport sink (input valid, req_type, slot_index, proc_id, arrival_time,
                burst_length, prio_level, output ready);
endinterface

// File: rtl/core/pps_rsp_if.sv
// Result channel: valid/ready handshake with one scheduler result.
interface pps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::OSLOT_W-1:0] chosen_slot;
  logic                        idle_tick;
  logic [pps_pkg::TIME_W-1:0]  time_now;
  logic                        slot_finished;
  logic [pps_pkg::PID_W-1:0]   out_proc_id;
  logic [pps_pkg::TIME_W-1:0]  completion_time;
  logic [pps_pkg::TIME_W-1:0]  turnaround_time;
  logic [pps_pkg::TIME_W-1:0]  waiting_time;
  logic                        all_done;

  modport source (output valid, chosen_slot, idle_tick, time_now, slot_finished,
                  out_proc_id, completion_time, turnaround_time, waiting_time,
                  all_done, input ready);
  modport sink (input valid, chosen_slot, idle_tick, time_now, slot_finished,
                out_proc_id, completion_time, turnaround_time, waiting_time,
                all_done, output ready);
endinterface

// File: rtl/core/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: controller, datapath and channels.
//
// Each accepted request returns exactly one result. A load writes a slot's pid,
// arrival, burst and priority and reports that slot; a read reports a slot's
// completion, turnaround and waiting times; a tick scans the active slots, runs
// the eligible one with the highest priority (lowest index on a tie), advances
// the saturating clock by one and reports the run slot, or flags an idle tick.
// The first tick moves the clock to the least arrival time loaded so far.
// Requests are handled one at a time. The priority scan of a tick reads one slot
// record per cycle through the single read port of the slot RAM. The block is
// ready for the next request in the cycle after the result is registered, even if
// that result is still waiting to be taken. active_count is written through
// cfg_we/cfg_data; the user must do so only while idle, as the block itself does
// not enforce it. Values above the slot count act as the full slot count.
module preemptive_priority_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pps_pkg::CFG_W-1:0] cfg_data,
  pps_req_if.sink                   in_chan,
  pps_rsp_if.source                 out_chan
);

  pps_pkg::dp_cmd_t  cmd;
  pps_pkg::dp_stat_t stat;

  // sequencer: one request in flight
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table, clock, scan and result register
  pps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .in_req_type         (in_chan.req_type),
    .in_slot_index       (in_chan.slot_index),
    .in_proc_id          (in_chan.proc_id),
    .in_arrival_time     (in_chan.arrival_time),
    .in_burst_length     (in_chan.burst_length),
    .in_prio_level       (in_chan.prio_level),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_chosen_slot     (out_chan.chosen_slot),
    .out_idle_tick       (out_chan.idle_tick),
    .out_time_now        (out_chan.time_now),
    .out_slot_finished   (out_chan.slot_finished),
    .out_proc_id         (out_chan.out_proc_id),
    .out_completion_time (out_chan.completion_time),
    .out_turnaround_time (out_chan.turnaround_time),
    .out_waiting_time    (out_chan.waiting_time),
    .out_all_done        (out_chan.all_done)
  );

endmodule

// File: rtl/core/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pps_ctrl.sv
// Sequencer for the scheduler: steps each request through the datapath.
module pps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pps_pkg::dp_stat_t stat,
  output pps_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOAD     = 4'd1;
  localparam logic [3:0] ST_TSTART   = 4'd2;
  localparam logic [3:0] ST_SCAN     = 4'd3;
  localparam logic [3:0] ST_DECIDE   = 4'd4;
  localparam logic [3:0] ST_RD_BEST  = 4'd5;
  localparam logic [3:0] ST_CAP_TICK = 4'd6;
  localparam logic [3:0] ST_RD_SLOT  = 4'd7;
  localparam logic [3:0] ST_CAP_READ = 4'd8;
  localparam logic [3:0] ST_TAT      = 4'd9;
  localparam logic [3:0] ST_WT       = 4'd10;
  localparam logic [3:0] ST_FINISH   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (stat.in_req)
            pps_pkg::REQ_LOAD: state_nxt = ST_LOAD;
            pps_pkg::REQ_TICK: state_nxt = ST_TSTART;
            pps_pkg::REQ_READ: state_nxt = ST_RD_SLOT;
            default:           state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.do_load = 1'b1;
        state_nxt   = ST_TAT;
      end
      ST_TSTART: begin
        cmd.tick_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.time_inc = 1'b1;
        state_nxt    = stat.found ? ST_RD_BEST : ST_FINISH;
      end
      ST_RD_BEST: begin
        cmd.rd_best = 1'b1;
        state_nxt   = ST_CAP_TICK;
      end
      ST_CAP_TICK: begin
        cmd.cap_tick = 1'b1;
        state_nxt    = ST_TAT;
      end
      ST_RD_SLOT: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = ST_CAP_READ;
      end
      ST_CAP_READ: begin
        cmd.cap_read = 1'b1;
        state_nxt    = ST_TAT;
      end
      ST_TAT: begin
        cmd.calc_tat = 1'b1;
        state_nxt    = ST_WT;
      end
      ST_WT: begin
        cmd.calc_wt = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/pps_dp.sv
// Scheduler datapath: slot RAM, clock, scan registers, report and output register.
module pps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pps_pkg::dp_cmd_t               cmd,
  output pps_pkg::dp_stat_t              stat,
  // configuration
  input  logic                           cfg_we,
  input  logic [pps_pkg::CFG_W-1:0]      cfg_data,
  // request payload
  input  logic [pps_pkg::REQ_W-1:0]      in_req_type,
  input  logic [pps_pkg::SLOT_W-1:0]     in_slot_index,
  input  logic [pps_pkg::PID_W-1:0]      in_proc_id,
  input  logic [pps_pkg::TIME_W-1:0]     in_arrival_time,
  input  logic [pps_pkg::BURST_W-1:0]    in_burst_length,
  input  logic [pps_pkg::PRIO_W-1:0]     in_prio_level,
  // result
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [pps_pkg::OSLOT_W-1:0]    out_chosen_slot,
  output logic                           out_idle_tick,
  output logic [pps_pkg::TIME_W-1:0]     out_time_now,
  output logic                           out_slot_finished,
  output logic [pps_pkg::PID_W-1:0]      out_proc_id,
  output logic [pps_pkg::TIME_W-1:0]     out_completion_time,
  output logic [pps_pkg::TIME_W-1:0]     out_turnaround_time,
  output logic [pps_pkg::TIME_W-1:0]     out_waiting_time,
  output logic                           out_all_done
);

  // captured request
  logic [pps_pkg::REQ_W-1:0]    req_r;
  logic [pps_pkg::SLOT_W-1:0]   slot_r;
  logic [pps_pkg::PID_W-1:0]    pid_r;
  logic [pps_pkg::TIME_W-1:0]   arr_r;
  logic [pps_pkg::BURST_W-1:0]  burst_r;
  logic [pps_pkg::PRIO_W-1:0]   prio_r;

  // control state
  logic [pps_pkg::CFG_W-1:0]    active_r;
  logic [pps_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic [pps_pkg::TIME_W-1:0]   least_r, least_nxt;
  logic                         started_r, started_nxt;
  logic [pps_pkg::NUM_SLOTS-1:0] busy_r, busy_nxt;
  logic [pps_pkg::CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // scan payload
  logic [pps_pkg::SLOT_W-1:0]   pend_idx_r;
  logic [pps_pkg::SLOT_W-1:0]   best_r;
  logic [pps_pkg::PRIO_W-1:0]   best_prio_r;

  // report registers
  logic [pps_pkg::PID_W-1:0]    rep_pid_r;
  logic [pps_pkg::TIME_W-1:0]   rep_arr_r;
  logic [pps_pkg::BURST_W-1:0]  rep_burst_r;
  logic [pps_pkg::BURST_W-1:0]  rep_rem_r;
  logic [pps_pkg::TIME_W-1:0]   rep_comp_r;
  logic [pps_pkg::TIME_W-1:0]   tat_r;
  logic [pps_pkg::TIME_W-1:0]   wt_r;

  // output register
  logic [pps_pkg::OSLOT_W-1:0]  o_slot_r;
  logic                         o_idle_r;
  logic [pps_pkg::TIME_W-1:0]   o_time_r;
  logic                         o_fin_r;
  logic [pps_pkg::PID_W-1:0]    o_pid_r;
  logic [pps_pkg::TIME_W-1:0]   o_comp_r;
  logic [pps_pkg::TIME_W-1:0]   o_tat_r;
  logic [pps_pkg::TIME_W-1:0]   o_wt_r;
  logic                         o_done_r;

  // RAM
  logic                         ram_we;
  logic [pps_pkg::SLOT_W-1:0]   ram_waddr, ram_raddr;
  pps_pkg::slot_rec_t           ram_wrec, ram_rrec, load_rec, upd_rec;
  logic [pps_pkg::REC_W-1:0]    ram_rdata;

  logic [pps_pkg::CNT_W-1:0]    n_eff;
  logic [pps_pkg::NUM_SLOTS-1:0] act_mask;
  logic                         all_done;
  logic                         issue;
  logic                         elig;

  assign ram_rrec = pps_pkg::slot_rec_t'(ram_rdata);

  always_comb begin
    if (32'(active_r) > pps_pkg::NUM_SLOTS) begin
      n_eff = pps_pkg::CNT_W'(pps_pkg::NUM_SLOTS);
    end else begin
      n_eff = pps_pkg::CNT_W'(active_r);
    end
    for (int i = 0; i < pps_pkg::NUM_SLOTS; i++) begin
      act_mask[i] = (i < 32'(n_eff));
    end
  end

  assign all_done = ((busy_r & act_mask) == '0);
  assign issue    = (scan_cnt_r < n_eff);
  assign elig     = pend_v_r && busy_r[pend_idx_r] && (ram_rrec.arrival <= time_r);

  always_comb begin
    load_rec.pid        = pid_r;
    load_rec.arrival    = arr_r;
    load_rec.burst      = burst_r;
    load_rec.remaining  = burst_r;
    load_rec.prio       = prio_r;
    load_rec.completion = '0;

    upd_rec            = ram_rrec;
    upd_rec.remaining  = ram_rrec.remaining - pps_pkg::BURST_W'(1);
    upd_rec.completion = time_r;

    ram_we    = cmd.do_load | cmd.cap_tick;
    ram_waddr = cmd.cap_tick ? best_r : slot_r;
    ram_wrec  = cmd.cap_tick ? upd_rec : load_rec;

    if (cmd.rd_best) begin
      ram_raddr = best_r;
    end else if (cmd.rd_slot) begin
      ram_raddr = slot_r;
    end else begin
      ram_raddr = scan_cnt_r[pps_pkg::SLOT_W-1:0];
    end
  end

  pps_ram #(
    .WIDTH (pps_pkg::REC_W),
    .DEPTH (pps_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control next state
  always_comb begin
    time_nxt      = time_r;
    least_nxt     = least_r;
    started_nxt   = started_r;
    busy_nxt      = busy_r;
    scan_cnt_nxt  = scan_cnt_r;
    pend_v_nxt    = pend_v_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;

    if (cmd.do_load) begin
      if (arr_r < least_r) begin
        least_nxt = arr_r;
      end
      busy_nxt[slot_r] = (burst_r != '0);
    end
    if (cmd.tick_start) begin
      if (!started_r) begin
        time_nxt    = least_r;
        started_nxt = 1'b1;
      end
      scan_cnt_nxt = '0;
      pend_v_nxt   = 1'b0;
      found_nxt    = 1'b0;
    end
    if (cmd.scan_step) begin
      pend_v_nxt = issue;
      if (issue) begin
        scan_cnt_nxt = scan_cnt_r + pps_pkg::CNT_W'(1);
      end
      if (elig) begin
        found_nxt = 1'b1;
      end
    end
    if (cmd.time_inc && (time_r != pps_pkg::TIME_MAX)) begin
      time_nxt = time_r + pps_pkg::TIME_W'(1);
    end
    if (cmd.cap_tick) begin
      busy_nxt[best_r] = (upd_rec.remaining != '0);
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      time_r      <= '0;
      least_r     <= pps_pkg::TIME_MAX;
      started_r   <= 1'b0;
      busy_r      <= '0;
      scan_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_data;
      end
      time_r      <= time_nxt;
      least_r     <= least_nxt;
      started_r   <= started_nxt;
      busy_r      <= busy_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      slot_r  <= in_slot_index;
      pid_r   <= in_proc_id;
      arr_r   <= in_arrival_time;
      burst_r <= in_burst_length;
      prio_r  <= in_prio_level;
    end
    if (cmd.scan_step && issue) begin
      pend_idx_r <= scan_cnt_r[pps_pkg::SLOT_W-1:0];
    end
    // strict > keeps the lowest index on equal priority
    if (elig && (!found_r || (ram_rrec.prio > best_prio_r))) begin
      best_r      <= pend_idx_r;
      best_prio_r <= ram_rrec.prio;
    end
    if (cmd.do_load) begin
      rep_pid_r   <= pid_r;
      rep_arr_r   <= arr_r;
      rep_burst_r <= burst_r;
      rep_rem_r   <= burst_r;
      rep_comp_r  <= '0;
    end
    if (cmd.cap_read) begin
      rep_pid_r   <= ram_rrec.pid;
      rep_arr_r   <= ram_rrec.arrival;
      rep_burst_r <= ram_rrec.burst;
      rep_rem_r   <= ram_rrec.remaining;
      rep_comp_r  <= ram_rrec.completion;
    end
    if (cmd.cap_tick) begin
      rep_pid_r   <= upd_rec.pid;
      rep_arr_r   <= upd_rec.arrival;
      rep_burst_r <= upd_rec.burst;
      rep_rem_r   <= upd_rec.remaining;
      rep_comp_r  <= upd_rec.completion;
    end
    if (cmd.calc_tat) begin
      tat_r <= (rep_comp_r >= rep_arr_r) ? (rep_comp_r - rep_arr_r) : '0;
    end
    if (cmd.calc_wt) begin
      wt_r <= (tat_r >= pps_pkg::TIME_W'(rep_burst_r))
              ? (tat_r - pps_pkg::TIME_W'(rep_burst_r)) : '0;
    end
    if (cmd.out_load) begin
      o_time_r <= time_r;
      o_done_r <= all_done;
      if ((req_r == pps_pkg::REQ_LOAD) || (req_r == pps_pkg::REQ_READ) ||
          ((req_r == pps_pkg::REQ_TICK) && found_r)) begin
        o_slot_r <= pps_pkg::OSLOT_W'((req_r == pps_pkg::REQ_TICK) ? best_r : slot_r);
        o_idle_r <= 1'b0;
        o_fin_r  <= (rep_rem_r == '0);
        o_pid_r  <= rep_pid_r;
        o_comp_r <= rep_comp_r;
        o_tat_r  <= tat_r;
        o_wt_r   <= wt_r;
      end else begin
        // idle tick or unused request: slot fields stay zero
        o_slot_r <= '0;
        o_idle_r <= (req_r == pps_pkg::REQ_TICK);
        o_fin_r  <= 1'b0;
        o_pid_r  <= '0;
        o_comp_r <= '0;
        o_tat_r  <= '0;
        o_wt_r   <= '0;
      end
    end
  end

  assign stat.in_req    = in_req_type;
  assign stat.scan_done = !pend_v_r && !issue;
  assign stat.found     = found_r;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_chosen_slot     = o_slot_r;
  assign out_idle_tick       = o_idle_r;
  assign out_time_now        = o_time_r;
  assign out_slot_finished   = o_fin_r;
  assign out_proc_id         = o_pid_r;
  assign out_completion_time = o_comp_r;
  assign out_turnaround_time = o_tat_r;
  assign out_waiting_time    = o_wt_r;
  assign out_all_done        = o_done_r;

endmodule

// File: bench/tb.sv
// Self-checking bench for the preemptive priority scheduler: directed table, then random requests.
`timescale 1ns / 100ps

module tb;
  import pps_pkg::*;

  // Request code the block does not use; it must change nothing.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // The first tick jumps the clock to the least arrival loaded. Starting a few hundred ticks
  // short of the top lets the random part run both below and at the saturated maximum.
  localparam logic [TIME_W-1:0] T_START = TIME_MAX - 16'd450;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [SLOT_W-1:0]  slot;
    logic [PID_W-1:0]   pid;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } sched_req_t;

  typedef struct packed {
    logic [OSLOT_W-1:0] chosen;
    logic               idle;
    logic [TIME_W-1:0]  now;
    logic               finished;
    logic [PID_W-1:0]   pid;
    logic [TIME_W-1:0]  completion;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic               all_done;
  } sched_res_t;

  // One directed row: optional active_count write beforehand, the request, and an
  // expected result typed in by hand where it is obvious.
  typedef struct {
    bit               cfg_en;
    logic [CFG_W-1:0] cfg_val;
    sched_req_t       req;
    bit               typed;
    sched_res_t       res;
  } dir_row_t;

  localparam sched_res_t NO_RES = '0;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  pps_req_if req_ch ();
  pps_rsp_if rsp_ch ();

  preemptive_priority_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  // ---------------------------------------------------------------------------------------
  // Scheduler state as the bench expects it to be
  // ---------------------------------------------------------------------------------------
  logic [TIME_W-1:0]  m_arrival [NUM_SLOTS];
  logic [BURST_W-1:0] m_burst   [NUM_SLOTS];
  logic [BURST_W-1:0] m_left    [NUM_SLOTS];
  logic [PRIO_W-1:0]  m_prio    [NUM_SLOTS];
  logic [PID_W-1:0]   m_pid     [NUM_SLOTS];
  logic [TIME_W-1:0]  m_done_at [NUM_SLOTS];
  logic [TIME_W-1:0]  m_clock;
  logic [TIME_W-1:0]  m_earliest;
  bit                 m_started;
  logic [CFG_W-1:0]   m_active;

  sched_res_t results_due [$];
  int         fail_count  = 0;
  int         sent_count  = 0;
  int         idle_stage  = 0;   // 0: sender idles 7%, receiver 47%; 1: swapped; 2: no idling
  int         stall_asked = 0;   // bumped by the stimulus to ask for one long receiver stall
  int         stall_seen  = 0;
  int         hold_left   = 0;

  // Directed table. Slot 1 and slot 2 arrive together with equal priority (lowest index wins),
  // slot 0 joins one tick later and wins on index, slot 3 then preempts with the top priority.
  // Slot 4 carries the field extremes and slot 5 has no work at all.
  dir_row_t directed_rows [25] = '{
    '{1'b0, 5'd0, '{REQ_SPARE, 4'd9, 8'hA5, 16'h5A5A, 12'hA5A, 8'h5A}, 1'b1,
      '{4'd0, 1'b0, 16'd0, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd0,  8'h00, T_START + 16'd1, 12'd2, 8'd10},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd1,  8'hFF, T_START,         12'd3, 8'd10},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd2,  8'h01, T_START,         12'd1, 8'd10},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd3,  8'h02, T_START + 16'd2, 12'd2, 8'hFF},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd4,  8'h03, 16'hFFFF,        12'hFFF, 8'h00}, 1'b1,
      '{4'd4, 1'b0, 16'd0, 1'b0, 8'h03, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd5,  8'h04, T_START,         12'd0, 8'hFF},  1'b1,
      '{4'd5, 1'b0, 16'd0, 1'b1, 8'h04, 16'd0, 16'd0, 16'd0, 1'b1}},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd6,  8'h10, T_START + 16'd3, 12'd1, 8'd7},   1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd7,  8'h21, T_START + 16'd4, 12'd2, 8'd7},   1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd8,  8'h32, T_START + 16'd5, 12'd3, 8'd200}, 1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd9,  8'h43, T_START + 16'd6, 12'd4, 8'd3},   1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd10, 8'h54, T_START + 16'd3, 12'd2, 8'd128}, 1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd11, 8'h65, T_START + 16'd7, 12'd1, 8'd0},   1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd12, 8'h76, T_START + 16'd8, 12'd2, 8'd64},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd13, 8'h87, T_START + 16'd4, 12'd3, 8'd7},   1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd14, 8'h98, T_START + 16'd9, 12'd1, 8'd99},  1'b0, NO_RES},
    '{1'b0, 5'd0, '{REQ_LOAD, 4'd15, 8'h5A, T_START + 16'd9, 12'd5, 8'd254}, 1'b0, NO_RES},
    // above the slot count: all sixteen take part; first tick jumps to the least arrival
    '{1'b1, 5'd31, '{REQ_TICK, 4'hF, 8'h00, 16'h0000, 12'h000, 8'h00}, 1'b0, NO_RES},
    '{1'b0, 5'd0,  '{REQ_TICK, 4'h0, 8'hFF, 16'hFFFF, 12'hFFF, 8'hFF}, 1'b0, NO_RES},
    '{1'b0, 5'd0,  '{REQ_TICK, 4'h7, 8'h3C, 16'h1234, 12'h321, 8'h11}, 1'b0, NO_RES},
    '{1'b0, 5'd0,  '{REQ_READ, 4'd1, 8'h00, 16'h0000, 12'h000, 8'h00}, 1'b0, NO_RES},
    // late load with arrival zero: least arrival moves but the clock must not
    '{1'b0, 5'd0,  '{REQ_LOAD, 4'd6, 8'h66, 16'h0000, 12'd1, 8'd1},    1'b0, NO_RES},
    '{1'b0, 5'd0,  '{REQ_READ, 4'd5, 8'hC3, 16'hC3C3, 12'hC3C, 8'h3C}, 1'b0, NO_RES},
    // single active slot: slot 0 finishes, then the next tick finds nothing to run
    '{1'b1, 5'd1,  '{REQ_TICK, 4'h2, 8'h00, 16'h0000, 12'h000, 8'h00}, 1'b0, NO_RES},
    '{1'b0, 5'd0,  '{REQ_TICK, 4'h2, 8'h00, 16'h0000, 12'h000, 8'h00}, 1'b0, NO_RES}
  };

  logic [CFG_W-1:0] phase_counts [RANDOM_PHASES] =
    '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd16, 5'd9, 5'd17, 5'd5, 5'd16};

  // ---------------------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------------------
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Expected behaviour
  // ---------------------------------------------------------------------------------------
  // active_count above the slot count means every slot
  function automatic int active_slots();
    return (m_active > NUM_SLOTS) ? NUM_SLOTS : int'(m_active);
  endfunction

  // Results of one slot; turnaround and waiting stop at zero rather than wrap.
  function automatic void fill_slot_report(input int s, inout sched_res_t r);
    logic [TIME_W-1:0] tat;
    tat = (m_done_at[s] >= m_arrival[s]) ? m_done_at[s] - m_arrival[s] : '0;
    r.finished   = (m_left[s] == '0);
    r.pid        = m_pid[s];
    r.completion = m_done_at[s];
    r.turnaround = tat;
    r.waiting    = (tat >= TIME_W'(m_burst[s])) ? tat - TIME_W'(m_burst[s]) : '0;
  endfunction

  // Applies one accepted request to the expected state and works out its result.
  task automatic schedule_request(input sched_req_t q, output sched_res_t r);
    int n;
    int best;
    int i;
    bit found;
    r     = '0;
    n     = active_slots();
    best  = 0;
    found = 1'b0;
    case (q.kind)
      REQ_LOAD: begin
        m_pid[q.slot]     = q.pid;
        m_arrival[q.slot] = q.arrival;
        m_burst[q.slot]   = q.burst;
        m_left[q.slot]    = q.burst;
        m_prio[q.slot]    = q.prio;
        m_done_at[q.slot] = '0;
        if (q.arrival < m_earliest) m_earliest = q.arrival;
        r.chosen = q.slot;
        fill_slot_report(q.slot, r);
      end
      REQ_TICK: begin
        if (!m_started) begin
          m_clock   = m_earliest;
          m_started = 1'b1;
        end
        // strict greater-than keeps the lowest index on a tie
        for (i = 0; i < n; i++) begin
          if (m_arrival[i] <= m_clock && m_left[i] != '0 &&
              (!found || m_prio[i] > m_prio[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (m_clock != TIME_MAX) m_clock = m_clock + 1'b1;
        if (found) begin
          m_left[best]    = m_left[best] - 1'b1;
          m_done_at[best] = m_clock;
          r.chosen        = OSLOT_W'(best);
          fill_slot_report(best, r);
        end else begin
          r.idle = 1'b1;
        end
      end
      REQ_READ: begin
        r.chosen = q.slot;
        fill_slot_report(q.slot, r);
      end
      default: ;
    endcase
    r.now      = m_clock;
    r.all_done = 1'b1;
    for (i = 0; i < n; i++) begin
      if (m_left[i] != '0) r.all_done = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------------------
  // Offers one request from the falling edge, with random gaps first, and records what
  // it should return once the block takes it.
  task automatic send_request(input sched_req_t q, input bit typed, input sched_res_t hand_res);
    sched_res_t r;
    idle_stage = (sent_count < 340) ? 0 : (sent_count < 680) ? 1 : 2;
    @(negedge clk);
    while ($urandom_range(99) < ((idle_stage == 0) ? 7 : (idle_stage == 1) ? 47 : 0)) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= q.kind;
    req_ch.slot_index   <= q.slot;
    req_ch.proc_id      <= q.pid;
    req_ch.arrival_time <= q.arrival;
    req_ch.burst_length <= q.burst;
    req_ch.prio_level   <= q.prio;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    schedule_request(q, r);
    results_due.push_back(typed ? hand_res : r);
    sent_count++;
  endtask

  // active_count is only written with the block idle: nothing offered, every result taken.
  task automatic program_active(input logic [CFG_W-1:0] count);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= count;
    m_active  = count;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random back-pressure plus one long stall on demand
  // ---------------------------------------------------------------------------------------
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_seen) begin
        stall_seen = stall_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >=
                         ((idle_stage == 0) ? 47 : (idle_stage == 1) ? 7 : 0));
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result returned with no request outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("chosen_slot",     want.chosen,     rsp_ch.chosen_slot);
        check_field("idle_tick",       want.idle,       rsp_ch.idle_tick);
        check_field("time_now",        want.now,        rsp_ch.time_now);
        check_field("slot_finished",   want.finished,   rsp_ch.slot_finished);
        check_field("out_proc_id",     want.pid,        rsp_ch.out_proc_id);
        check_field("completion_time", want.completion, rsp_ch.completion_time);
        check_field("turnaround_time", want.turnaround, rsp_ch.turnaround_time);
        check_field("waiting_time",    want.waiting,    rsp_ch.waiting_time);
        check_field("all_done",        want.all_done,   rsp_ch.all_done);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  initial begin
    sched_req_t q;
    int pick;
    int n_act;
    int near;
    int ph;
    int k;
    int sat_ticks;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.slot_index   <= '0;
    req_ch.proc_id      <= '0;
    req_ch.arrival_time <= '0;
    req_ch.burst_length <= '0;
    req_ch.prio_level   <= '0;

    foreach (m_pid[i]) begin
      m_arrival[i] = '0;
      m_burst[i]   = '0;
      m_left[i]    = '0;
      m_prio[i]    = '0;
      m_pid[i]     = '0;
      m_done_at[i] = '0;
    end
    m_clock    = '0;
    m_earliest = TIME_MAX;
    m_started  = 1'b0;
    m_active   = '0;

    // reset low from the start, released on a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Every slot is loaded here, so no later request can touch an
    // unwritten slot.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_en) program_active(directed_rows[i].cfg_val);
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random part, one active_count setting per phase. Arrivals mostly sit just around
    // the current time so that slots keep joining the race; priorities are often drawn
    // from a tiny range to force ties.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_active(phase_counts[ph]);
      // one long receiver stall while requests keep coming, to fill the block up
      if (ph == 5) stall_asked++;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        n_act  = active_slots();
        pick   = $urandom_range(99);
        q.kind = (pick < 45) ? REQ_TICK : (pick < 75) ? REQ_LOAD :
                 (pick < 95) ? REQ_READ : REQ_SPARE;
        q.slot = (n_act > 0 && $urandom_range(3) != 0) ?
                 SLOT_W'($urandom_range(n_act - 1)) : SLOT_W'($urandom);
        q.pid  = PID_W'($urandom);
        case ($urandom_range(9))
          0: q.arrival = TIME_W'($urandom);
          1: q.arrival = $urandom_range(1) ? TIME_MAX : '0;
          default: begin
            near = int'(m_clock) + int'($urandom_range(24)) - 8;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            q.arrival = TIME_W'(near);
          end
        endcase
        case ($urandom_range(9))
          0: q.burst = BURST_W'($urandom);
          1: q.burst = '0;
          default: q.burst = BURST_W'($urandom_range(12, 1));
        endcase
        q.prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
        send_request(q, 1'b0, NO_RES);
      end
    end

    // Tick on until the clock has sat at its maximum for a few ticks.
    sat_ticks = 0;
    while (sat_ticks < 4) begin
      if (m_clock == TIME_MAX) sat_ticks++;
      q      = '0;
      q.kind = REQ_TICK;
      q.slot = SLOT_W'($urandom);
      send_request(q, 1'b0, NO_RES);
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pps_pkg.sv
rtl/core/pps_req_if.sv
rtl/core/pps_rsp_if.sv
rtl/core/pps_ram.sv
rtl/core/pps_ctrl.sv
rtl/core/pps_dp.sv
rtl/core/preemptive_priority_scheduler.sv
bench/tb.sv
